// ===== rtl/core/svm_pkg.sv =====
// ----------------------------------------------------------------------------
// svm_pkg: shared types and constants of the linear SVM block
//
// Holds the 48-bit accumulator type, its saturation limits, the request and
// response bundles of the shared multiplier, and the saturating add and subtract helpers.
// ----------------------------------------------------------------------------
package svm_pkg;

  localparam int ACC_W = 48;
  localparam int CFG_W = 8;
  localparam int OUT_W = 72;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [ACC_W:0]   acc_wide_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam acc_t ONE_Q   = acc_t'(32'sh0001_0000);
  localparam acc_t ZERO_Q  = '0;

  localparam logic [CFG_W-1:0] VLEN_RESET = 8'd128;

  // Input command codes
  localparam logic CMD_SUPPORT = 1'b0;
  localparam logic CMD_SAMPLE  = 1'b1;

  typedef struct packed {
    logic start;
    acc_t a;
    acc_t b;
  } mul_req_t;

  typedef struct packed {
    logic done;
    acc_t product;
  } mul_rsp_t;

  // Clamp a one-bit-wider sum back into the accumulator range
  function automatic acc_t sat_wide(acc_wide_t s);
    acc_t r;
    if (s[ACC_W] != s[ACC_W-1]) begin
      r = s[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      r = s[ACC_W-1:0];
    end
    return r;
  endfunction

  function automatic acc_t sat_add(acc_t a, acc_t b);
    acc_wide_t s;
    s = acc_wide_t'(a) + acc_wide_t'(b);
    return sat_wide(s);
  endfunction

  function automatic acc_t sat_sub(acc_t a, acc_t b);
    acc_wide_t s;
    s = acc_wide_t'(a) - acc_wide_t'(b);
    return sat_wide(s);
  endfunction

endpackage

// ===== rtl/core/svm_mul.sv =====
// ----------------------------------------------------------------------------
// svm_mul: shared Q16.16 multiplier
//
// Forms sat48(a*b / 2^16), truncated toward zero, on magnitudes. The second
// operand is taken 16 bits a cycle from the top, so the array is 48x16.
// Result and done are registered together in the finalize step.
// ----------------------------------------------------------------------------
module svm_mul
  import svm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic              busy;
  logic [1:0]        step;
  logic              neg;
  logic [ACC_W-1:0]  ma;
  logic [ACC_W-1:0]  mb;
  logic [95:0]       prod;
  logic [63:0]       digit_prod;
  logic              ovf;
  acc_t              mag;
  acc_t              result;
  logic              done;
  acc_t              product;

  // One partial product per cycle
  assign digit_prod = 64'(ma) * 64'(mb[ACC_W-1:ACC_W-16]);

  // Truncated magnitude and saturation
  assign ovf = |prod[95:63];
  assign mag = {1'b0, prod[62:16]};

  always_comb begin
    if (neg) begin
      result = ovf ? ACC_MIN : -mag;
    end else begin
      result = ovf ? ACC_MAX : mag;
    end
  end

  // Response bundle
  assign rsp = '{done: done, product: product};

  // Control: load, three digit steps, finalize
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (req.start) begin
          busy <= 1'b1;
          step <= '0;
        end
      end else if (step == 2'd3) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        step <= step + 2'd1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (!busy) begin
      if (req.start) begin
        ma   <= req.a[ACC_W-1] ? (~req.a + 1'b1) : req.a;
        mb   <= req.b[ACC_W-1] ? (~req.b + 1'b1) : req.b;
        neg  <= req.a[ACC_W-1] ^ req.b[ACC_W-1];
        prod <= '0;
      end
    end else if (step == 2'd3) begin
      product <= result;
    end else begin
      prod <= (prod << 16) + 96'(digit_prod);
      mb   <= mb << 16;
    end
  end

endmodule

// ===== rtl/core/svm_mem.sv =====
// ----------------------------------------------------------------------------
// svm_mem: weight and reference memories
//
// Two single-port style arrays with registered reads at a shared
// read address. The weight array has its own write address for write-back
// and the reset sweep; the reference array is written at the read address.
// ----------------------------------------------------------------------------
module svm_mem
  import svm_pkg::*;
#(
  parameter int MAX_FEATURES = 128,
  parameter int VALUE_BITS   = 32,
  parameter int POS_W        = 7
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [POS_W-1:0]             raddr,
  input  logic                         w_we,
  input  logic [POS_W-1:0]             w_waddr,
  input  acc_t                         w_wdata,
  output acc_t                         w_rdata,
  input  logic                         r_we,
  input  logic signed [VALUE_BITS-1:0] r_wdata,
  output logic signed [VALUE_BITS-1:0] r_rdata
);

  acc_t                         wmem [MAX_FEATURES];
  logic signed [VALUE_BITS-1:0] rmem [MAX_FEATURES];

  // Weight array
  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= w_wdata;
    end
    if (rd_en) begin
      w_rdata <= wmem[raddr];
    end
  end

  // Reference vector array
  always_ff @(posedge clk) begin
    if (r_we) begin
      rmem[raddr] <= r_wdata;
    end
    if (rd_en) begin
      r_rdata <= rmem[raddr];
    end
  end

endmodule

// ===== rtl/core/linear_svm_plane_build_and_classify.sv =====
// ----------------------------------------------------------------------------
// linear_svm_plane_build_and_classify: linear SVM plane builder and classifier
//
// Feature items arrive one at a time, by position. Support-vector features
// (tuser 0) add coef*x into the weight memory, the first vector is kept as the
// reference and sets the bias; sample features (tuser 1) sum bias + w.x and
// the last feature of a sample yields one result. All values are Q16.16 with
// 48-bit saturating accumulators. Every product goes through one shared
// 48x16 multiplier in three digit steps. A sample feature needs one product
// and a support-vector feature two, with one more at the end of the vector
// for the bias update. After reset the weight memory is swept to zero before
// the first item is taken; configuration writes are taken at any time. A
// result waits in the output register while the next items are taken.
// ----------------------------------------------------------------------------
module linear_svm_plane_build_and_classify
  import svm_pkg::*;
#(
  parameter int MAX_FEATURES = 128,
  parameter int VALUE_BITS   = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // s_tdata: coefficient, feature_value
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [((2*VALUE_BITS+7)/8)*8-1:0]       s_tdata,
  // s_tuser: command
  input  logic                                    s_tuser,
  // m_tdata: predicted_positive, matches_label, samples_seen, samples_right
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [OUT_W-1:0]                        m_tdata,
  // vector_length
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [CFG_W-1:0]                        cfg_data
);

  localparam int POS_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int LEN_W = ($clog2(MAX_FEATURES + 1) > CFG_W) ?
                         $clog2(MAX_FEATURES + 1) : CFG_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MUL_W = 3'd2;
  localparam logic [2:0] S_MUL_D = 3'd3;
  localparam logic [2:0] S_MUL_B = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]       state;
  logic [POS_W-1:0] clr_addr;
  logic             mul_pend;

  logic [CFG_W-1:0] vlen;
  logic [POS_W-1:0] fpos;
  logic             loaded;
  acc_t             held;
  acc_t             bias;
  acc_t             acc;
  logic [31:0]      sample_count;
  logic [31:0]      right_count;

  logic             it_cmd;
  logic [POS_W-1:0] it_pos;
  logic             it_last;
  acc_t             it_x;

  logic                         accept;
  logic signed [VALUE_BITS-1:0] in_coef;
  logic signed [VALUE_BITS-1:0] in_x;
  acc_t                         coef_ext;
  logic [LEN_W-1:0]             len_eff;
  logic [LEN_W-1:0]             pos_inc;
  logic                         last;

  mul_req_t                     mreq;
  mul_rsp_t                     mrsp;
  logic                         w_we;
  logic [POS_W-1:0]             w_waddr;
  acc_t                         w_wdata;
  acc_t                         w_rdata;
  logic                         r_we;
  logic signed [VALUE_BITS-1:0] r_rdata;

  logic                         out_fire;
  logic                         pred;
  logic                         match;
  logic [31:0]                  sample_count_next;
  logic [31:0]                  right_count_next;

  // Input fields and handshake
  assign in_coef  = s_tdata[VALUE_BITS-1:0];
  assign in_x     = s_tdata[2*VALUE_BITS-1:VALUE_BITS];
  assign coef_ext = acc_t'(in_coef);
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid & s_tready;
  assign cfg_ready = 1'b1;

  // Effective length and end of vector
  always_comb begin
    if (vlen == '0) begin
      len_eff = LEN_W'(1);
    end else if (LEN_W'(vlen) > LEN_W'(MAX_FEATURES)) begin
      len_eff = LEN_W'(MAX_FEATURES);
    end else begin
      len_eff = LEN_W'(vlen);
    end
  end

  assign pos_inc = LEN_W'(fpos) + LEN_W'(1);
  assign last    = (pos_inc >= len_eff);

  // Memories: read at the accept edge, write back after the product
  assign r_we    = accept & (s_tuser == CMD_SUPPORT) & !loaded;
  assign w_we    = (state == S_CLEAR) || ((state == S_MUL_W) && mrsp.done);
  assign w_waddr = (state == S_CLEAR) ? clr_addr : it_pos;
  assign w_wdata = (state == S_CLEAR) ? ZERO_Q : sat_add(w_rdata, mrsp.product);

  svm_mem #(
    .MAX_FEATURES (MAX_FEATURES),
    .VALUE_BITS   (VALUE_BITS),
    .POS_W        (POS_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .raddr   (fpos),
    .w_we    (w_we),
    .w_waddr (w_waddr),
    .w_wdata (w_wdata),
    .w_rdata (w_rdata),
    .r_we    (r_we),
    .r_wdata (in_x),
    .r_rdata (r_rdata)
  );

  // Multiplier operands by step
  always_comb begin
    mreq.start = 1'b0;
    mreq.a     = it_x;
    mreq.b     = it_x;
    unique case (state)
      S_MUL_W: begin
        mreq.start = !mul_pend;
        mreq.a     = held;
        mreq.b     = it_x;
      end
      S_MUL_D: begin
        mreq.start = !mul_pend;
        if (it_cmd == CMD_SAMPLE) begin
          mreq.a = w_rdata;
          mreq.b = it_x;
        end else begin
          mreq.a = it_x;
          mreq.b = loaded ? acc_t'(r_rdata) : it_x;
        end
      end
      S_MUL_B: begin
        mreq.start = !mul_pend;
        mreq.a     = held;
        mreq.b     = acc;
      end
      default: begin
        mreq.start = 1'b0;
      end
    endcase
  end

  svm_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  // Result and counters
  assign out_fire = (state == S_OUT) && (!m_tvalid || m_tready);
  assign pred     = !acc[ACC_W-1];
  assign match    = pred ? (held > ZERO_Q) : (held < ZERO_Q);
  assign sample_count_next = (sample_count != '1) ? sample_count + 32'd1 : sample_count;
  assign right_count_next  = (match && right_count != '1) ? right_count + 32'd1
                                                          : right_count;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vlen <= VLEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      vlen <= cfg_data;
    end
  end

  // Sequencer and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      mul_pend     <= 1'b0;
      fpos         <= '0;
      loaded       <= 1'b0;
      held         <= ZERO_Q;
      bias         <= ZERO_Q;
      acc          <= ZERO_Q;
      sample_count <= '0;
      right_count  <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (mreq.start) begin
        mul_pend <= 1'b1;
      end
      if (mrsp.done) begin
        mul_pend <= 1'b0;
      end

      unique case (state)
        // Sweep the weight memory to zero
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == POS_W'(MAX_FEATURES - 1)) begin
            state <= S_IDLE;
          end
        end

        // Take an item, set up the vector on its first feature
        S_IDLE: begin
          if (accept) begin
            it_cmd  <= s_tuser;
            it_pos  <= fpos;
            it_last <= last;
            it_x    <= acc_t'(in_x);
            fpos    <= last ? '0 : fpos + 1'b1;
            if (fpos == '0) begin
              held <= coef_ext;
              if (s_tuser == CMD_SAMPLE) begin
                acc <= bias;
              end else begin
                acc <= ZERO_Q;
                if (!loaded) begin
                  bias <= (coef_ext > ZERO_Q) ? ONE_Q : -ONE_Q;
                end
              end
            end
            state <= (s_tuser == CMD_SAMPLE) ? S_MUL_D : S_MUL_W;
          end
        end

        // Weight write-back happens on done
        S_MUL_W: begin
          if (mrsp.done) begin
            state <= S_MUL_D;
          end
        end

        // Accumulate the dot product
        S_MUL_D: begin
          if (mrsp.done) begin
            acc <= sat_add(acc, mrsp.product);
            if (!it_last) begin
              state <= S_IDLE;
            end else if (it_cmd == CMD_SAMPLE) begin
              state <= S_OUT;
            end else begin
              state <= S_MUL_B;
            end
          end
        end

        // Reduce the bias at the end of a support vector
        S_MUL_B: begin
          if (mrsp.done) begin
            bias   <= sat_sub(bias, mrsp.product);
            acc    <= ZERO_Q;
            loaded <= 1'b1;
            state  <= S_IDLE;
          end
        end

        // Hold until the output register is free, then load it
        S_OUT: begin
          if (out_fire) begin
            sample_count <= sample_count_next;
            right_count  <= right_count_next;
            m_tvalid     <= 1'b1;
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (out_fire) begin
      m_tdata <= {6'b0, right_count_next, sample_count_next, match, pred};
    end
  end

endmodule
